// ===== hdl/dft_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the delimiter-separated field tokenizer.
// Used by dft_step and dsv_field_tokenizer_top; depends on nothing.
package dft_pkg;

    localparam int SPACE_COUNT_BITS = 8;
    // The held-space count never goes past 255, so its counter is at most eight bits wide.
    localparam int HELD_W = (SPACE_COUNT_BITS > 8) ? 8 : SPACE_COUNT_BITS;

    localparam logic [7:0] QUOTE_RESET = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'h2C;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_NUL      = 8'h00;

    localparam logic [1:0] KIND_DELIM     = 2'd0;
    localparam logic [1:0] KIND_LINE      = 2'd1;
    localparam logic [1:0] KIND_INPUT     = 2'd2;
    localparam logic [1:0] KIND_OPEN_QUOT = 2'd3;

    localparam logic REG_QUOTE = 1'b0;
    localparam logic REG_DELIM = 1'b1;

    typedef enum logic [1:0] {
        PH_START,
        PH_UNQUOT,
        PH_QUOTE,
        PH_QSEEN
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [7:0] spaces_first;
        logic       quote_first;
        logic       field_done;
        logic [1:0] end_kind;
        logic       space_overflow;
    } result_t;

endpackage

// ===== hdl/dft_step.sv =====
`timescale 1ns / 1ps
// Per-byte parse logic: classifies one byte against the current phase and
// the held-space count and produces the result and the next state. Uses dft_pkg.
module dft_step
    import dft_pkg::*;
(
    input  logic [7:0]        in_byte,
    input  phase_t            phase,
    input  logic [HELD_W-1:0] held,
    input  logic [7:0]        quote_char,
    input  logic [7:0]        delimiter_char,
    output result_t           result,
    output phase_t            phase_next,
    output logic [HELD_W-1:0] held_next
);

    localparam logic [HELD_W-1:0] SPACE_MAX = '1;

    logic       is_quote;
    logic       is_delim;
    logic       is_line_end;
    logic       is_space;
    logic [1:0] kind_of;

    assign is_quote    = (quote_char != CH_NUL) && (in_byte == quote_char);
    assign is_delim    = (in_byte == delimiter_char);
    assign is_line_end = (in_byte == CH_LF) || (in_byte == CH_CR) || (in_byte == CH_NUL);
    assign is_space    = (in_byte == CH_SPACE);
    // Byte 0 reports input end, even when it equals the delimiter (inside quotes it reports an open quote).
    assign kind_of     = (in_byte == CH_NUL) ? KIND_INPUT :
                         (is_delim ? KIND_DELIM : KIND_LINE);

    function automatic logic [HELD_W:0] sat_inc(input logic [HELD_W-1:0] h);
        logic [HELD_W:0] r;
        if (h == SPACE_MAX)
        begin
            r = {1'b1, SPACE_MAX};
        end
        else
        begin
            r = {1'b0, h + HELD_W'(1)};
        end
        return r;
    endfunction

    always_comb
    begin
        phase_next = phase;
        case (phase)
            PH_START:
            begin
                if (is_line_end || (!is_quote && is_delim) || (!is_quote && is_space))
                begin
                    phase_next = PH_START;
                end
                else if (is_quote)
                begin
                    phase_next = PH_QUOTE;
                end
                else
                begin
                    phase_next = PH_UNQUOT;
                end
            end
            PH_UNQUOT:
            begin
                if (is_delim || is_line_end)
                begin
                    phase_next = PH_START;
                end
            end
            PH_QUOTE:
            begin
                if (is_quote)
                begin
                    phase_next = PH_QSEEN;
                end
                else if (in_byte == CH_NUL)
                begin
                    phase_next = PH_START;
                end
            end
            PH_QSEEN:
            begin
                if (is_quote)
                begin
                    phase_next = PH_QUOTE;
                end
                else if (is_delim || is_line_end)
                begin
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = PH_QUOTE;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    always_comb
    begin
        logic              do_app;
        logic              stray;
        logic              done;
        logic [1:0]        kind;
        logic [HELD_W-1:0] h;
        logic [HELD_W:0]   inc;
        logic              ovf;
        logic              qf;
        logic [HELD_W-1:0] sp;
        logic [7:0]        ob;
        logic              bv;

        do_app = 1'b0;
        stray  = 1'b0;
        done   = 1'b0;
        kind   = KIND_DELIM;
        ovf    = 1'b0;
        qf     = 1'b0;
        sp     = '0;
        ob     = 8'h00;
        bv     = 1'b0;
        h      = held;
        inc    = '0;

        case (phase)
            PH_START:
            begin
                if (is_line_end)
                begin
                    done = 1'b1;
                    kind = kind_of;
                end
                else if (is_quote)
                begin
                    done = 1'b0;
                end
                else if (is_delim)
                begin
                    done = 1'b1;
                    kind = kind_of;
                end
                else if (!is_space)
                begin
                    do_app = 1'b1;
                end
            end
            PH_UNQUOT:
            begin
                if (is_delim || is_line_end)
                begin
                    done = 1'b1;
                    kind = kind_of;
                end
                else
                begin
                    do_app = 1'b1;
                end
            end
            PH_QUOTE:
            begin
                if (is_quote)
                begin
                    done = 1'b0;
                end
                else if (in_byte == CH_NUL)
                begin
                    done = 1'b1;
                    kind = KIND_OPEN_QUOT;
                end
                else
                begin
                    do_app = 1'b1;
                end
            end
            PH_QSEEN:
            begin
                if (is_quote)
                begin
                    do_app = 1'b1;
                end
                else if (is_delim || is_line_end)
                begin
                    done = 1'b1;
                    kind = kind_of;
                end
                else
                begin
                    do_app = 1'b1;
                    stray  = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        if (do_app)
        begin
            // A stray quote goes out ahead of the byte; a space quote is held instead.
            if (stray)
            begin
                if (quote_char == CH_SPACE)
                begin
                    inc = sat_inc(h);
                    h   = inc[HELD_W-1:0];
                    ovf = ovf | inc[HELD_W];
                end
                else
                begin
                    sp = h;
                    h  = '0;
                    qf = 1'b1;
                end
            end
            if (is_space)
            begin
                inc = sat_inc(h);
                h   = inc[HELD_W-1:0];
                ovf = ovf | inc[HELD_W];
            end
            else
            begin
                if (!qf)
                begin
                    sp = h;
                end
                h  = '0;
                ob = in_byte;
                bv = 1'b1;
            end
        end

        if (done)
        begin
            h = '0;
        end

        held_next             = h;
        result.out_byte       = ob;
        result.byte_valid     = bv;
        result.spaces_first   = 8'(sp);
        result.quote_first    = qf;
        result.field_done     = done;
        result.end_kind       = kind;
        result.space_overflow = ovf;
    end

endmodule

// ===== hdl/dsv_field_tokenizer_top.sv =====
`timescale 1ns / 1ps
// Top level of the delimiter-separated field tokenizer: stream ports,
// configuration registers, input and result registers. Uses dft_pkg and dft_step.
//
// Usage:
//   Bytes enter on the s_ channel, one byte per transaction (0 ends the input).
//   Every byte gives exactly one result transaction on the m_ channel: a kept
//   byte with the spaces and stray quote to append first, and on tlast the
//   closing of a field, its end kind in tuser.
//   The quote and delimiter bytes are set through cfg_we/cfg_addr/cfg_wdata
//   (index 0 quote, 1 delimiter) while no transaction is in flight.
// Timing:
//   A byte is captured in the input register, parsed by one level of logic and
//   written to the result register once that register is free, and its result is
//   then offered on the m_ channel. One byte per cycle is sustained while m_tready
//   is high; the parse state loop (phase and held spaces) runs only through
//   dft_step, from phase_reg and held_reg back to them.
// Reset and stall:
//   Reset empties both registers, returns the parser to record start with no
//   held spaces, and loads quote 0x22 and delimiter 0x2C.
//   When m_tready is low the result register holds; the input register still
//   takes one more byte, after which s_tready drops until the result leaves.
module dsv_field_tokenizer_top
    import dft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte, [8] byte_valid, [16:9] spaces_first, [17] quote_first,
    // [18] space_overflow, [23:19] zero
    output logic [23:0] m_tdata,
    output logic        m_tlast,    // field_done
    output logic [1:0]  m_tuser,    // [1:0] end_kind
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0]        quote_reg;
    logic [7:0]        delim_reg;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    result_t           step_res;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg <= QUOTE_RESET;
            delim_reg <= DELIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_QUOTE: quote_reg <= cfg_wdata;
                REG_DELIM: delim_reg <= cfg_wdata;
                default:   quote_reg <= quote_reg;
            endcase
        end
    end

    dft_step u_step (
        .in_byte        (in_byte_reg),
        .phase          (phase_reg),
        .held           (held_reg),
        .quote_char     (quote_reg),
        .delimiter_char (delim_reg),
        .result         (step_res),
        .phase_next     (phase_next),
        .held_next      (held_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            held_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.space_overflow, out_res_reg.quote_first,
                       out_res_reg.spaces_first, out_res_reg.byte_valid,
                       out_res_reg.out_byte};
    assign m_tlast  = out_res_reg.field_done;
    assign m_tuser  = out_res_reg.end_kind;

`ifndef SYNTHESIS
    a_close_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.field_done |=> phase_reg == PH_START && held_reg == '0)
        else $error("field close did not return parser to record start");

    a_kind_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == KIND_DELIM)
        else $error("end kind set on a result that does not close a field");

    a_kept_byte_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.byte_valid |=> held_reg == '0)
        else $error("held spaces remain after a kept byte");

    a_no_drop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("buffered byte lost while the result side stalled");
`endif

endmodule
